// ----- rtl/apd_pkg.sv -----
// ----------------------------------------------------------------------------
// All-pairs shortest path package
// Shared constants, input kind codes and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package apd_pkg;

    localparam int NODE_COUNT = 4;
    localparam int NODE_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int IDX_W      = 3;
    localparam int COST_W     = 10;
    localparam int DIST_W     = 13;
    localparam int KIND_W     = 2;

    localparam logic [IDX_W:0]      NODE_LIMIT = (IDX_W + 1)'(NODE_COUNT);
    localparam logic [NODE_W-1:0]   NODE_LAST  = NODE_W'(NODE_COUNT - 1);

    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UPDATE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

    typedef struct packed {
        logic              wr_direct;
        logic              wr_swap;
        logic              rd_src;
        logic              init;
        logic              search;
        logic              relax;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dest;
    } t_dp_cmd;

endpackage

// ----- rtl/apd_datapath.sv -----
// ----------------------------------------------------------------------------
// All-pairs shortest path datapath
// Row-wide cost memory, working distances, visited flags, minimum search
// and parallel relaxation across one cost row.
// ----------------------------------------------------------------------------
module apd_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  apd_pkg::t_dp_cmd            i_cmd,
    input  logic [apd_pkg::IDX_W-1:0]   i_node_a,
    input  logic [apd_pkg::IDX_W-1:0]   i_node_b,
    input  logic [apd_pkg::COST_W-1:0]  i_link_cost,
    output logic [apd_pkg::DIST_W-1:0]  o_path_distance
);
    import apd_pkg::*;

    typedef logic [NODE_COUNT-1:0][COST_W-1:0] t_row;

    t_row                mem [NODE_COUNT];
    t_row                r_row;
    logic [DIST_W-1:0]   r_dist [NODE_COUNT];
    logic [NODE_COUNT-1:0] r_visited;
    logic [NODE_W-1:0]   r_pick;
    logic [NODE_W-1:0]   r_wr_a;
    logic [NODE_W-1:0]   r_wr_b;
    logic [COST_W-1:0]   r_wr_cost;

    logic [DIST_W:0]     best;
    logic [NODE_W-1:0]   pick;
    logic [NODE_W-1:0]   rd_row;

    always_comb begin
        best = '1;
        pick = '0;
        for (int j = 0; j < NODE_COUNT; j++) begin
            if (!r_visited[j] && ({1'b0, r_dist[j]} < best)) begin
                best = {1'b0, r_dist[j]};
                pick = NODE_W'(j);
            end
        end
    end

    assign rd_row = i_cmd.search ? pick : i_cmd.src;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_direct) begin
            mem[i_node_a[NODE_W-1:0]][i_node_b[NODE_W-1:0]] <= i_link_cost;
        end else if (i_cmd.wr_swap) begin
            mem[r_wr_b][r_wr_a] <= r_wr_cost;
        end
        if (i_cmd.rd_src || i_cmd.search) begin
            r_row <= mem[rd_row];
        end
        if (i_cmd.wr_direct) begin
            r_wr_a    <= i_node_a[NODE_W-1:0];
            r_wr_b    <= i_node_b[NODE_W-1:0];
            r_wr_cost <= i_link_cost;
        end
        if (i_cmd.search) begin
            r_pick <= pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited <= '0;
            for (int j = 0; j < NODE_COUNT; j++) begin
                r_dist[j] <= '0;
            end
        end else if (i_cmd.init) begin
            r_visited <= '0;
            for (int j = 0; j < NODE_COUNT; j++) begin
                r_dist[j] <= DIST_W'(r_row[j]);
            end
        end else if (i_cmd.search) begin
            r_visited[pick] <= 1'b1;
        end else if (i_cmd.relax) begin
            for (int j = 0; j < NODE_COUNT; j++) begin
                if (!r_visited[j] &&
                    (({1'b0, r_dist[r_pick]} + (DIST_W + 1)'(r_row[j]))
                     < {1'b0, r_dist[j]})) begin
                    r_dist[j] <= r_dist[r_pick] + DIST_W'(r_row[j]);
                end
            end
        end
    end

    assign o_path_distance = r_dist[i_cmd.dest];

endmodule

// ----- rtl/apd_controller.sv -----
// ----------------------------------------------------------------------------
// All-pairs shortest path controller
// Sequences cost writes, per-source search and relaxation rounds, and the
// emission of one distance row per source.
// ----------------------------------------------------------------------------
module apd_controller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [apd_pkg::KIND_W-1:0]  i_kind,
    input  logic [apd_pkg::IDX_W-1:0]   i_node_a,
    input  logic [apd_pkg::IDX_W-1:0]   i_node_b,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [apd_pkg::IDX_W-1:0]   o_source_node,
    output logic [apd_pkg::IDX_W-1:0]   o_dest_node,
    output logic                        o_last,
    output apd_pkg::t_dp_cmd            o_cmd
);
    import apd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWAP,
        S_ROW,
        S_LOAD,
        S_SEARCH,
        S_RELAX,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [NODE_W-1:0] r_src;
    logic [NODE_W-1:0] r_round;
    logic [NODE_W-1:0] r_dest;

    logic accept;
    logic in_range;

    assign accept   = i_in_valid && o_in_ready;
    assign in_range = ({1'b0, i_node_a} < NODE_LIMIT) && ({1'b0, i_node_b} < NODE_LIMIT);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_source_node = IDX_W'(r_src);
    assign o_dest_node   = IDX_W'(r_dest);
    assign o_last        = (r_src == NODE_LAST) && (r_dest == NODE_LAST);

    always_comb begin
        o_cmd           = '0;
        o_cmd.src       = r_src;
        o_cmd.dest      = r_dest;
        o_cmd.wr_direct = accept && in_range &&
                          ((i_kind == KIND_LOAD) || (i_kind == KIND_UPDATE));
        o_cmd.wr_swap   = (r_state == S_SWAP);
        o_cmd.rd_src    = (r_state == S_ROW);
        o_cmd.init      = (r_state == S_LOAD);
        o_cmd.search    = (r_state == S_SEARCH);
        o_cmd.relax     = (r_state == S_RELAX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_src   <= '0;
            r_round <= '0;
            r_dest  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if ((i_kind == KIND_UPDATE) && in_range) begin
                            r_state <= S_SWAP;
                        end else if (i_kind == KIND_COMPUTE) begin
                            r_src   <= '0;
                            r_state <= S_ROW;
                        end
                    end
                end
                S_SWAP: begin
                    r_state <= S_IDLE;
                end
                S_ROW: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_round <= '0;
                    r_state <= S_SEARCH;
                end
                S_SEARCH: begin
                    r_state <= S_RELAX;
                end
                S_RELAX: begin
                    if (r_round == NODE_LAST) begin
                        r_dest  <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_round <= r_round + 1'b1;
                        r_state <= S_SEARCH;
                    end
                end
                S_EMIT: begin
                    if (i_out_ready) begin
                        if (r_dest == NODE_LAST) begin
                            if (r_src == NODE_LAST) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_src   <= r_src + 1'b1;
                                r_state <= S_ROW;
                            end
                        end else begin
                            r_dest <= r_dest + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/all_pairs_dijkstra_cost_matrix.sv -----
// A load writes its cost and keeps the block ready; an update then writes the
// mirrored cost in a swap state. A compute holds the input not ready until its
// last result is taken and is ready in the cycle after: per source a row read,
// a load, a search and a relax state in each of NODE_COUNT rounds, then one
// result per cycle while the output is ready. Reset is synchronous, active low,
// and clears control state; the cost memory is not cleared.
// ----------------------------------------------------------------------------
// All-pairs shortest path over a dense cost matrix
// Holds an N-by-N link cost matrix and emits all least distances on request.
// ----------------------------------------------------------------------------
module all_pairs_dijkstra_cost_matrix (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [apd_pkg::KIND_W-1:0]  i_kind,
    input  logic [apd_pkg::IDX_W-1:0]   i_node_a,
    input  logic [apd_pkg::IDX_W-1:0]   i_node_b,
    input  logic [apd_pkg::COST_W-1:0]  i_link_cost,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [apd_pkg::IDX_W-1:0]   o_source_node,
    output logic [apd_pkg::IDX_W-1:0]   o_dest_node,
    output logic [apd_pkg::DIST_W-1:0]  o_path_distance,
    output logic                        o_last
);
    import apd_pkg::*;

    t_dp_cmd cmd;

    apd_controller u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_node_a      (i_node_a),
        .i_node_b      (i_node_b),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_source_node (o_source_node),
        .o_dest_node   (o_dest_node),
        .o_last        (o_last),
        .o_cmd         (cmd)
    );

    apd_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_node_a        (i_node_a),
        .i_node_b        (i_node_b),
        .i_link_cost     (i_link_cost),
        .o_path_distance (o_path_distance)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && o_in_ready))
        else $error("input accepted while results are pending");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_kind == KIND_COMPUTE)) |=> !o_in_ready)
        else $error("compute transaction did not occupy the block");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> (o_in_ready && !o_out_valid))
        else $error("block not idle after final result");

    a_not_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |=> !o_in_ready)
        else $error("block went idle before final result");

endmodule
